[sv/ppg_pkg.sv]
// Shared types, widths, calibration ROM and output conversion for the ground projection block.
package ppg_pkg;

    localparam int NUM_CAMERAS     = 4;
    localparam int ROM_CAMS        = 4;
    localparam int COORD_FRAC_BITS = 8;
    localparam int WORK_FRAC       = 16;

    localparam int PIX_W   = 16;
    localparam int CAM_W   = 2;
    localparam int OUT_W   = 32;
    localparam int DU_W    = 22;
    localparam int FOC_W   = 18;
    localparam int ROT_W   = 17;
    localparam int NX_W    = 40;
    localparam int PROD_W  = 57;
    localparam int RAY_W   = 59;
    localparam int RMAG_W  = RAY_W - 1;
    localparam int TZM_W   = 32;
    localparam int RLO_W   = 29;
    localparam int RHI_W   = RMAG_W - RLO_W;
    localparam int PP_W    = TZM_W + RLO_W;
    localparam int NUM_W   = TZM_W + RMAG_W;
    localparam int Q_W     = 50;
    localparam int MAG_W   = Q_W + 1;
    localparam int SUM_W   = 54;
    localparam int DIV_STEPS = Q_W;
    localparam int DIV_LAT   = DIV_STEPS + 1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam int OUT_SHIFT = WORK_FRAC - COORD_FRAC_BITS;
    localparam int RND       = (OUT_SHIFT > 0) ? (1 << (OUT_SHIFT - 1)) : 0;
    localparam logic signed [SUM_W-1:0] RND_V = SUM_W'(RND);
    localparam logic signed [SUM_W-1:0] OMAX  = {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] OMIN  = {{(SUM_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic [CAM_W-1:0] camera_select;
    } t_in_beat;

    typedef struct packed {
        logic signed [OUT_W-1:0] vehicle_x;
        logic signed [OUT_W-1:0] vehicle_y;
        logic signed [OUT_W-1:0] vehicle_z;
        logic                    range_fault;
    } t_out_beat;

    typedef struct packed {
        logic signed [DU_W-1:0] du;
        logic signed [DU_W-1:0] dv;
        logic [CAM_W-1:0]       cam;
        logic                   bad;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic signed [FOC_W-1:0]  fx;
        logic signed [FOC_W-1:0]  fy;
        logic signed [DU_W-1:0]   cx;
        logic signed [DU_W-1:0]   cy;
        logic [0:8][ROT_W-1:0]    rot;
        logic signed [31:0]       nw;
        logic signed [31:0]       tz;
        logic signed [31:0]       tvx;
        logic signed [31:0]       tvy;
        logic signed [31:0]       tvz;
    } t_cam;

    typedef struct packed {
        logic                    sat;
        logic signed [OUT_W-1:0] val;
    } t_conv;

    function automatic t_cam cam_rom(logic [CAM_W-1:0] cam);
        t_cam e;
        e = '0;
        case (cam)
            2'd0: begin
                e.fx = 18'sd36194; e.fy = 18'sd36190;
                e.cx = 22'sd98146; e.cy = 22'sd66445;
                e.rot = {-17'sd1082, 17'sd33895, -17'sd56080, 17'sd65520, 17'sd1409,
                         -17'sd412, 17'sd993, -17'sd56073, -17'sd33909};
                e.tz = 32'sd59913798;
                e.tvx = -32'sd79167488; e.tvy = 32'sd0; e.tvz = 32'sd38207488;
            end
            2'd1: begin
                e.fx = 18'sd36408; e.fy = 18'sd36393;
                e.cx = 22'sd98234; e.cy = 22'sd66246;
                e.rot = {17'sd328, -17'sd18628, 17'sd62832, -17'sd65530, 17'sd708,
                         17'sd553, -17'sd836, -17'sd62829, -17'sd18622};
                e.tz = 32'sd51034635;
                e.tvx = 32'sd232325120; e.tvy = 32'sd0; e.tvz = 32'sd26083328;
            end
            2'd2: begin
                e.fx = 18'sd36355; e.fy = 18'sd36340;
                e.cx = 22'sd98116; e.cy = 22'sd66299;
                e.rot = {17'sd65535, -17'sd356, -17'sd161, -17'sd97, -17'sd40888,
                         17'sd51216, -17'sd379, -17'sd51215, -17'sd40888};
                e.tz = 32'sd76059547;
                e.tvx = 32'sd154948731; e.tvy = 32'sd73084436; e.tvz = 32'sd81075241;
            end
            2'd3: begin
                e.fx = 18'sd36286; e.fy = 18'sd36269;
                e.cx = 22'sd98141; e.cy = 22'sd66352;
                e.rot = {-17'sd65535, -17'sd288, -17'sd121, -17'sd93, 17'sd42227,
                         -17'sd50118, 17'sd298, -17'sd50117, -17'sd42227};
                e.tz = 32'sd75940104;
                e.tvx = 32'sd126484480; e.tvy = -32'sd69206016; e.tvz = 32'sd51970048;
            end
            default: e = '0;
        endcase
        e.nw = 32'(32'(e.fx) * 32'(e.fy));
        return e;
    endfunction

    // Q.16 to output fraction bits, round half up, saturate to 32 bits
    function automatic t_conv conv_out(logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        t_conv c;
        r = (v + RND_V) >>> OUT_SHIFT;
        c.sat = 1'b0;
        if (r > OMAX) begin
            c.sat = 1'b1;
            r = OMAX;
        end else if (r < OMIN) begin
            c.sat = 1'b1;
            r = OMIN;
        end
        c.val = r[OUT_W-1:0];
        return c;
    endfunction

endpackage

[sv/pixel_to_ground_projection.sv]
// Top level of the pixel to ground plane projection block.
//
// Input channel: i_in_valid / o_in_stall with i_in_beat (pixel_x, pixel_y in
// unsigned 12.4 pixels, camera_select). A beat is taken on a rising edge with
// valid high and stall low.
// Output channel: o_out_valid / i_out_stall with o_out_beat (vehicle x, y, z
// in signed Q23.8 mm, range_fault).
// Throughput: one beat per cycle while the receiver does not stall.
// Pipeline depth is set by the pipelined divider that forms -Tz*ray/ray_z,
// one quotient bit per stage, plus the ray and multiply stages before it
// and the sum and output stages after it.
// The front stage feeds a 4-entry job queue; the back pipeline pulls from it.
// When the receiver stalls while the output is valid, the whole back
// pipeline and the output register freeze; the front keeps taking beats
// until the queue fills, then raises o_in_stall.
// Reset (synchronous, active low) clears the queue and every valid bit; no
// clearing pass is needed, the block takes beats on the first cycle after.
module pixel_to_ground_projection (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ppg_pkg::t_in_beat   i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ppg_pkg::t_out_beat  o_out_beat
);
    import ppg_pkg::*;

    t_qstat q_stat;
    t_job   front_job;
    logic   front_valid;
    t_job   q_job;
    logic   q_pop;

    // front: classify and center the pixel
    ppg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .i_qstat     (q_stat),
        .o_job_valid (front_valid),
        .o_job       (front_job)
    );

    // decoupling queue
    ppg_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_job        (front_job),
        .i_pop        (q_pop),
        .o_qstat      (q_stat),
        .o_job        (q_job)
    );

    // back: projection math and output register
    ppg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (q_stat),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

    // reset empties the output
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // input back-pressure only comes from a full queue
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_stat.full)
        else $error("input stalled while queue has room");

    // queue status is consistent
    a_q_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

endmodule

[sv/ppg_front.sv]
// Input stage: takes pixel beats, centers them on the camera's principal point, flags bad cameras.
module ppg_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ppg_pkg::t_in_beat  i_in_beat,
    input  ppg_pkg::t_qstat    i_qstat,
    output logic               o_job_valid,
    output ppg_pkg::t_job      o_job
);
    import ppg_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_job  r_job;
    t_job  n_job;
    t_cam  e;
    logic  accept;
    logic  push;

    assign push       = r_valid && !i_qstat.full;
    assign o_in_stall = r_valid && i_qstat.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_valid    = accept || (r_valid && !push);

    always_comb begin
        e         = cam_rom(i_in_beat.camera_select);
        n_job.du  = $signed({2'b00, i_in_beat.pixel_x, 4'b0000}) - e.cx;
        n_job.dv  = $signed({2'b00, i_in_beat.pixel_y, 4'b0000}) - e.cy;
        n_job.cam = i_in_beat.camera_select;
        n_job.bad = (int'(i_in_beat.camera_select) >= NUM_CAMERAS)
                 || (int'(i_in_beat.camera_select) >= ROM_CAMS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;

endmodule

[sv/ppg_fifo.sv]
// Short job queue between the front and back stages.
module ppg_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  ppg_pkg::t_job   i_job,
    input  logic            i_pop,
    output ppg_pkg::t_qstat o_qstat,
    output ppg_pkg::t_job   o_job
);
    import ppg_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              push;
    logic              pop;

    assign o_qstat.full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign push          = i_push_valid && !o_qstat.full;
    assign pop           = i_pop && !o_qstat.empty;
    assign o_job         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

[sv/ppg_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module ppg_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [ppg_pkg::NUM_W-1:0]  i_num,
    input  logic [ppg_pkg::RMAG_W-1:0] i_den,
    output logic [ppg_pkg::Q_W-1:0]    o_quot,
    output logic                       o_ovf
);
    import ppg_pkg::*;

    logic [RMAG_W-1:0] r_rem [DIV_STEPS+1];
    logic [Q_W-1:0]    r_w   [DIV_STEPS+1];
    logic [RMAG_W-1:0] r_d   [DIV_STEPS+1];
    logic              r_ovf [DIV_STEPS+1];
    logic [RMAG_W:0]   n_t   [DIV_STEPS+1];
    logic              n_ge  [DIV_STEPS+1];
    logic [NUM_W-Q_W-1:0] num_hi;

    assign num_hi = i_num[NUM_W-1:Q_W];

    always_comb begin
        n_t[0]  = '0;
        n_ge[0] = 1'b0;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            n_t[k]  = {r_rem[k-1], r_w[k-1][Q_W-1]};
            n_ge[k] = n_t[k] >= {1'b0, r_d[k-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= (i_den == '0) || (RMAG_W'(num_hi) >= i_den);
            r_rem[0] <= RMAG_W'(num_hi);
            r_w[0]   <= i_num[Q_W-1:0];
            r_d[0]   <= i_den;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_rem[k] <= n_ge[k] ? RMAG_W'(n_t[k] - {1'b0, r_d[k-1]})
                                    : n_t[k][RMAG_W-1:0];
                r_w[k]   <= {r_w[k-1][Q_W-2:0], n_ge[k]};
                r_d[k]   <= r_d[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quot = r_w[DIV_STEPS];
    assign o_ovf  = r_ovf[DIV_STEPS];

endmodule

[sv/ppg_back.sv]
// Execution pipeline: ray forming, ground intersection, offset add, rounding and output register.
module ppg_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ppg_pkg::t_qstat     i_qstat,
    input  ppg_pkg::t_job       i_job,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output ppg_pkg::t_out_beat  o_out_beat
);
    import ppg_pkg::*;

    logic adv;

    // stage 1: focal products
    logic                    r1_v;
    logic signed [NX_W-1:0]  r1_nx;
    logic signed [NX_W-1:0]  r1_ny;
    logic [CAM_W-1:0]        r1_cam;
    logic                    r1_bad;
    t_cam                    e1;

    // stage 2: rotation products
    logic                     r2_v;
    logic signed [PROD_W-1:0] r2_p [9];
    logic [CAM_W-1:0]         r2_cam;
    logic                     r2_bad;
    t_cam                     e2;

    // stage 3: ray
    logic                    r3_v;
    logic signed [RAY_W-1:0] r3_ray [3];
    logic [CAM_W-1:0]        r3_cam;
    logic                    r3_bad;
    t_cam                    e3;

    // stage 4: magnitudes and partial products
    logic                 r4_v;
    logic [PP_W-1:0]      r4_plo_x;
    logic [PP_W-1:0]      r4_phi_x;
    logic [PP_W-1:0]      r4_plo_y;
    logic [PP_W-1:0]      r4_phi_y;
    logic [RMAG_W-1:0]    r4_d;
    logic                 r4_zero;
    logic                 r4_neg_x;
    logic                 r4_neg_y;
    logic signed [31:0]   r4_tvx;
    logic signed [31:0]   r4_tvy;
    logic signed [SUM_W-1:0] r4_vz;
    logic                 r4_bad;
    logic [TZM_W-1:0]     tz_mag;
    logic [RMAG_W-1:0]    mag_x;
    logic [RMAG_W-1:0]    mag_y;
    logic [RMAG_W-1:0]    mag_z;

    // stage 5: dividends
    logic                 r5_v;
    logic [NUM_W-1:0]     r5_num_x;
    logic [NUM_W-1:0]     r5_num_y;
    logic [RMAG_W-1:0]    r5_d;
    logic                 r5_zero;
    logic                 r5_neg_x;
    logic                 r5_neg_y;
    logic signed [31:0]   r5_tvx;
    logic signed [31:0]   r5_tvy;
    logic signed [SUM_W-1:0] r5_vz;
    logic                 r5_bad;

    // sideband matched to divider latency
    logic                    r6_v     [DIV_LAT];
    logic                    r6_zero  [DIV_LAT];
    logic                    r6_neg_x [DIV_LAT];
    logic                    r6_neg_y [DIV_LAT];
    logic signed [31:0]      r6_tvx   [DIV_LAT];
    logic signed [31:0]      r6_tvy   [DIV_LAT];
    logic signed [SUM_W-1:0] r6_vz    [DIV_LAT];
    logic                    r6_bad   [DIV_LAT];
    logic [Q_W-1:0]          q_x;
    logic [Q_W-1:0]          q_y;
    logic                    ovf_x;
    logic                    ovf_y;

    // stage 7: sums
    logic                    r7_v;
    logic signed [SUM_W-1:0] r7_sx;
    logic signed [SUM_W-1:0] r7_sy;
    logic signed [SUM_W-1:0] r7_vz;
    logic                    r7_zero;
    logic                    r7_bad;
    logic [MAG_W-1:0]        mag_off_x;
    logic [MAG_W-1:0]        mag_off_y;
    logic signed [SUM_W-1:0] off_x;
    logic signed [SUM_W-1:0] off_y;

    // output
    logic      r_o_valid;
    t_out_beat r_o_beat;
    t_out_beat n_o_beat;
    t_conv     cx;
    t_conv     cy;
    t_conv     cz;

    localparam int LAST = DIV_LAT - 1;

    assign adv   = !(r_o_valid && i_out_stall);
    assign o_pop = adv && !i_qstat.empty;

    always_comb begin
        e1 = cam_rom(i_job.cam);
        e2 = cam_rom(r1_cam);
        e3 = cam_rom(r3_cam);
        tz_mag = e3.tz[31] ? TZM_W'(-e3.tz) : TZM_W'(e3.tz);
        mag_x  = r3_ray[0][RAY_W-1] ? RMAG_W'(-r3_ray[0]) : RMAG_W'(r3_ray[0]);
        mag_y  = r3_ray[1][RAY_W-1] ? RMAG_W'(-r3_ray[1]) : RMAG_W'(r3_ray[1]);
        mag_z  = r3_ray[2][RAY_W-1] ? RMAG_W'(-r3_ray[2]) : RMAG_W'(r3_ray[2]);
    end

    always_comb begin
        mag_off_x = (r6_zero[LAST] || ovf_x) ? (MAG_W'(1) << Q_W) : {1'b0, q_x};
        mag_off_y = (r6_zero[LAST] || ovf_y) ? (MAG_W'(1) << Q_W) : {1'b0, q_y};
        off_x = r6_neg_x[LAST] ? $signed(SUM_W'(mag_off_x)) : -$signed(SUM_W'(mag_off_x));
        off_y = r6_neg_y[LAST] ? $signed(SUM_W'(mag_off_y)) : -$signed(SUM_W'(mag_off_y));
    end

    always_comb begin
        cx = conv_out(r7_sx);
        cy = conv_out(r7_sy);
        cz = conv_out(r7_vz);
        if (r7_bad) begin
            n_o_beat = '0;
            n_o_beat.range_fault = 1'b1;
        end else begin
            n_o_beat.vehicle_x   = cx.val;
            n_o_beat.vehicle_y   = cy.val;
            n_o_beat.vehicle_z   = cz.val;
            n_o_beat.range_fault = r7_zero || cx.sat || cy.sat || cz.sat;
        end
    end

    ppg_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  (r5_num_x),
        .i_den  (r5_d),
        .o_quot (q_x),
        .o_ovf  (ovf_x)
    );

    ppg_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_num  (r5_num_y),
        .i_den  (r5_d),
        .o_quot (q_y),
        .o_ovf  (ovf_y)
    );

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            r4_v      <= 1'b0;
            r5_v      <= 1'b0;
            r7_v      <= 1'b0;
            r_o_valid <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r6_v[k] <= 1'b0;
            end
        end else if (adv) begin
            r1_v      <= !i_qstat.empty;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r4_v      <= r3_v;
            r5_v      <= r4_v;
            r6_v[0]   <= r5_v;
            for (int k = 1; k < DIV_LAT; k++) begin
                r6_v[k] <= r6_v[k-1];
            end
            r7_v      <= r6_v[LAST];
            r_o_valid <= r7_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_nx  <= NX_W'(i_job.du) * NX_W'(e1.fy);
            r1_ny  <= NX_W'(i_job.dv) * NX_W'(e1.fx);
            r1_cam <= i_job.cam;
            r1_bad <= i_job.bad;

            for (int r = 0; r < 3; r++) begin
                r2_p[3*r]   <= PROD_W'($signed(e2.rot[3*r]))   * PROD_W'(r1_nx);
                r2_p[3*r+1] <= PROD_W'($signed(e2.rot[3*r+1])) * PROD_W'(r1_ny);
                r2_p[3*r+2] <= PROD_W'($signed(e2.rot[3*r+2])) * PROD_W'(e2.nw);
            end
            r2_cam <= r1_cam;
            r2_bad <= r1_bad;

            for (int r = 0; r < 3; r++) begin
                r3_ray[r] <= RAY_W'(r2_p[3*r]) + RAY_W'(r2_p[3*r+1]) + RAY_W'(r2_p[3*r+2]);
            end
            r3_cam <= r2_cam;
            r3_bad <= r2_bad;

            r4_plo_x <= PP_W'(tz_mag) * PP_W'(mag_x[RLO_W-1:0]);
            r4_phi_x <= PP_W'(tz_mag) * PP_W'(mag_x[RMAG_W-1:RLO_W]);
            r4_plo_y <= PP_W'(tz_mag) * PP_W'(mag_y[RLO_W-1:0]);
            r4_phi_y <= PP_W'(tz_mag) * PP_W'(mag_y[RMAG_W-1:RLO_W]);
            r4_d     <= mag_z;
            r4_zero  <= (r3_ray[2] == '0);
            r4_neg_x <= e3.tz[31] ^ r3_ray[0][RAY_W-1] ^ r3_ray[2][RAY_W-1];
            r4_neg_y <= e3.tz[31] ^ r3_ray[1][RAY_W-1] ^ r3_ray[2][RAY_W-1];
            r4_tvx   <= e3.tvx;
            r4_tvy   <= e3.tvy;
            r4_vz    <= SUM_W'(e3.tvz) - SUM_W'(e3.tz);
            r4_bad   <= r3_bad;

            r5_num_x <= NUM_W'(r4_plo_x) + (NUM_W'(r4_phi_x) << RLO_W);
            r5_num_y <= NUM_W'(r4_plo_y) + (NUM_W'(r4_phi_y) << RLO_W);
            r5_d     <= r4_d;
            r5_zero  <= r4_zero;
            r5_neg_x <= r4_neg_x;
            r5_neg_y <= r4_neg_y;
            r5_tvx   <= r4_tvx;
            r5_tvy   <= r4_tvy;
            r5_vz    <= r4_vz;
            r5_bad   <= r4_bad;

            r6_zero[0]  <= r5_zero;
            r6_neg_x[0] <= r5_neg_x;
            r6_neg_y[0] <= r5_neg_y;
            r6_tvx[0]   <= r5_tvx;
            r6_tvy[0]   <= r5_tvy;
            r6_vz[0]    <= r5_vz;
            r6_bad[0]   <= r5_bad;
            for (int k = 1; k < DIV_LAT; k++) begin
                r6_zero[k]  <= r6_zero[k-1];
                r6_neg_x[k] <= r6_neg_x[k-1];
                r6_neg_y[k] <= r6_neg_y[k-1];
                r6_tvx[k]   <= r6_tvx[k-1];
                r6_tvy[k]   <= r6_tvy[k-1];
                r6_vz[k]    <= r6_vz[k-1];
                r6_bad[k]   <= r6_bad[k-1];
            end

            r7_sx   <= SUM_W'(r6_tvx[LAST]) + off_x;
            r7_sy   <= SUM_W'(r6_tvy[LAST]) + off_y;
            r7_vz   <= r6_vz[LAST];
            r7_zero <= r6_zero[LAST];
            r7_bad  <= r6_bad[LAST];

            r_o_beat <= n_o_beat;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_beat  = r_o_beat;

endmodule

[bench/tb_pixel_to_ground_projection.sv]
// Self-checking testbench for the pixel to ground plane projection block.
//
// Each accepted input beat is projected by a local predictor and queued; each
// accepted output beat is checked field by field against the oldest entry in
// that queue. The predictor keeps its own copy of the four camera calibrations.
// All arithmetic is exact: the ray uses 64-bit integers, and the ground
// intersection uses a 128-bit product and divide.
module tb_pixel_to_ground_projection;
    import ppg_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 80;
    localparam longint OFS_LIMIT  = 64'sd1 << 50;
    localparam longint OUT_HI     = 64'sd2147483647;
    localparam longint OUT_LO     = -64'sd2147483648;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_beat   i_in_beat;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_beat  o_out_beat;

    pixel_to_ground_projection i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    // Camera calibration: focal lengths and principal point (Q.8 px), rotation
    // (Q.16), camera height and vehicle offset (Q.16 mm).
    longint cal_fx [4] = '{36194, 36408, 36355, 36286};
    longint cal_fy [4] = '{36190, 36393, 36340, 36269};
    longint cal_cx [4] = '{98146, 98234, 98116, 98141};
    longint cal_cy [4] = '{66445, 66246, 66299, 66352};
    longint cal_tz [4] = '{59913798, 51034635, 76059547, 75940104};
    longint cal_tvx[4] = '{-79167488, 232325120, 154948731, 126484480};
    longint cal_tvy[4] = '{0, 0, 73084436, -69206016};
    longint cal_tvz[4] = '{38207488, 26083328, 81075241, 51970048};
    longint cal_rot[4][9] = '{
        '{-1082, 33895, -56080, 65520, 1409, -412, 993, -56073, -33909},
        '{328, -18628, 62832, -65530, 708, 553, -836, -62829, -18622},
        '{65535, -356, -161, -97, -40888, 51216, -379, -51215, -40888},
        '{-65535, -288, -121, -93, 42227, -50118, 298, -50117, -42227}
    };

    t_out_beat ground_q[$];       // projections waiting for their output beat
    int        err_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_req;          // cycles of forced receiver hold-off to start
    int        hold_left;
    int        quiet_cycles;

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Offset along one axis: -tz*ray_a/ray_z in Q.16 mm, magnitude capped.
    // A zero ray_z takes the capped magnitude and raises the fault.
    function automatic longint plane_offset(longint tz, longint ray_a, longint ray_z,
                                            ref bit fault);
        bit          neg_quot;
        logic [127:0] prod;
        logic [127:0] quot;
        longint      mag;
        neg_quot = ((tz < 0) ^ (ray_a < 0)) ^ (ray_z < 0);
        mag = OFS_LIMIT;
        if (ray_z == 0) begin
            fault = 1'b1;
        end else begin
            prod = 128'(tz < 0 ? -tz : tz) * 128'(ray_a < 0 ? -ray_a : ray_a);
            quot = prod / 128'(ray_z < 0 ? -ray_z : ray_z);
            if (quot < 128'(OFS_LIMIT))
                mag = longint'(quot);
        end
        return neg_quot ? mag : -mag;
    endfunction

    // Q.16 to output fraction bits: round half up (floor of v+half), saturate.
    function automatic logic signed [OUT_W-1:0] to_mm(longint v, ref bit fault);
        longint r;
        r = (v + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        if (r > OUT_HI) begin
            r = OUT_HI;
            fault = 1'b1;
        end
        if (r < OUT_LO) begin
            r = OUT_LO;
            fault = 1'b1;
        end
        return r[OUT_W-1:0];
    endfunction

    function automatic t_out_beat project_pixel(t_in_beat b);
        t_out_beat res;
        int        c;
        bit        fault;
        longint    du, dv, nx, ny, nw;
        longint    ray[3];
        c = int'(b.camera_select);
        fault = 1'b0;
        res = '0;
        if (c >= NUM_CAMERAS || c >= ROM_CAMS) begin
            res.range_fault = 1'b1;
            return res;
        end
        du = longint'(b.pixel_x) * 16 - cal_cx[c];
        dv = longint'(b.pixel_y) * 16 - cal_cy[c];
        nx = du * cal_fy[c];
        ny = dv * cal_fx[c];
        nw = cal_fx[c] * cal_fy[c];
        for (int r = 0; r < 3; r++)
            ray[r] = cal_rot[c][3*r] * nx + cal_rot[c][3*r+1] * ny + cal_rot[c][3*r+2] * nw;
        res.vehicle_x = to_mm(cal_tvx[c] + plane_offset(cal_tz[c], ray[0], ray[2], fault), fault);
        res.vehicle_y = to_mm(cal_tvy[c] + plane_offset(cal_tz[c], ray[1], ray[2], fault), fault);
        res.vehicle_z = to_mm(cal_tvz[c] - cal_tz[c], fault);
        res.range_fault = fault;
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Clock, receiver stall, scoreboard, watchdog
    // ---------------------------------------------------------------------

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Receiver: random stall at the current idle rate, or a long hold-off
    // when a test asks for one. Only this process counts the hold-off down.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_req - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Push on accepted input beats, compare on accepted output beats. An
    // input beat passes through the registered pipeline before it reaches the
    // output, so push and pop never meet on the same entry.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && i_in_valid && !o_in_stall)
            ground_q.push_back(project_pixel(i_in_beat));
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (ground_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("ERROR: output beat with nothing expected: x=%0d y=%0d z=%0d f=%0b",
                             o_out_beat.vehicle_x, o_out_beat.vehicle_y,
                             o_out_beat.vehicle_z, o_out_beat.range_fault);
            end else begin
                want = ground_q.pop_front();
                if (o_out_beat.vehicle_x !== want.vehicle_x
                        || o_out_beat.vehicle_y !== want.vehicle_y
                        || o_out_beat.vehicle_z !== want.vehicle_z
                        || o_out_beat.range_fault !== want.range_fault) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("ERROR: got x=%0d y=%0d z=%0d f=%0b, want x=%0d y=%0d z=%0d f=%0b",
                                 o_out_beat.vehicle_x, o_out_beat.vehicle_y,
                                 o_out_beat.vehicle_z, o_out_beat.range_fault,
                                 want.vehicle_x, want.vehicle_y,
                                 want.vehicle_z, want.range_fault);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus tasks
    // ---------------------------------------------------------------------

    // Offer one beat, with a random idle gap first; returns on acceptance.
    task automatic send_pixel(logic [15:0] px, logic [15:0] py, logic [1:0] cam);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= '{pixel_x: px, pixel_y: py, camera_select: cam};
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (ground_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Realistic pixel inside the image most of the time, any 16-bit value else.
    function automatic logic [15:0] pick_coord();
        if ($urandom_range(99) < 80)
            return 16'($urandom_range(1023 * 16 + 15));
        return 16'($urandom());
    endfunction

    // Field extremes, principal point, a row near the principal point and
    // alternating-bit patterns, on every camera.
    task automatic test_directed();
        for (int c = 0; c < 4; c++) begin
            send_pixel(16'h0000, 16'h0000, 2'(c));
            send_pixel(16'hFFFF, 16'hFFFF, 2'(c));
            send_pixel(16'(cal_cx[c] / 16), 16'(cal_cy[c] / 16), 2'(c));
            send_pixel(16'hAAAA, 16'h5555, 2'(c));
            send_pixel(16'h5555, 16'hAAAA, 2'(c));
            send_pixel(16'h0000, 16'(cal_cy[c] / 16 - 16), 2'(c));
        end
        wait_for_drain();
    endtask

    task automatic test_random(int count, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int n = 0; n < count; n++)
            send_pixel(pick_coord(), pick_coord(), 2'($urandom_range(3)));
        wait_for_drain();
    endtask

    // Long receiver hold-off while the sender keeps offering beats, so the
    // pipeline and job queue fill and the input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= 300;
        @(posedge i_clk);
        hold_req <= 0;
        for (int n = 0; n < 100; n++)
            send_pixel(pick_coord(), pick_coord(), 2'($urandom_range(3)));
        wait_for_drain();
    endtask

    initial begin
        err_count     = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_beat     = '0;
        i_out_stall   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(230, 31, 87);
        test_random(230, 87, 31);
        test_backpressure();
        test_random(230, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && ground_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
